// ===== rtl/vbc_pkg.sv =====
// ----------------------------------------------------------------------------
// vbc_pkg
// Shared types, constants and alphabet lookups for the byte cipher.
// ----------------------------------------------------------------------------
package vbc_pkg;

  localparam int KEY_BYTES   = 16;
  localparam int KEY_POS_W   = 4;
  localparam int KEY_LEN_W   = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;

  localparam logic [8:0] SYMBOLS = 9'd161;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LEN  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECRYPT  = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [7:0] idx;
  } sym_idx_t;

  // One classified byte on its way from front to back.
  typedef struct packed {
    logic [7:0] msg_byte;
    logic [7:0] msg_idx;
    logic       msg_ok;
    logic [7:0] key_idx;
    logic       key_ok;
    logic       decrypt;
    logic       last;
  } vbc_item_t;

  // Alphabet position of a Windows-1251 byte; ok is low outside the alphabet.
  function automatic sym_idx_t sym_index(input logic [7:0] b);
    sym_idx_t r;
    r.ok  = 1'b1;
    r.idx = 8'd0;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r.idx = b - 8'h41;
    end else if (b >= 8'h61 && b <= 8'h7A) begin
      r.idx = b - 8'h61 + 8'd26;
    end else if (b >= 8'hC0 && b <= 8'hC5) begin
      r.idx = b - 8'hC0 + 8'd52;
    end else if (b == 8'hA8) begin
      r.idx = 8'd58;
    end else if (b >= 8'hC6 && b <= 8'hDF) begin
      r.idx = b - 8'hC6 + 8'd59;
    end else if (b >= 8'hE0 && b <= 8'hE5) begin
      r.idx = b - 8'hE0 + 8'd85;
    end else if (b == 8'hB8) begin
      r.idx = 8'd91;
    end else if (b >= 8'hE6) begin
      r.idx = b - 8'hE6 + 8'd92;
    end else if (b >= 8'h30 && b <= 8'h39) begin
      r.idx = b - 8'h30 + 8'd118;
    end else if (b == 8'h20) begin
      r.idx = 8'd128;
    end else if (b >= 8'h21 && b <= 8'h2F) begin
      r.idx = b - 8'h21 + 8'd129;
    end else if (b >= 8'h3A && b <= 8'h40) begin
      r.idx = b - 8'h3A + 8'd144;
    end else if (b >= 8'h5B && b <= 8'h60) begin
      r.idx = b - 8'h5B + 8'd151;
    end else if (b >= 8'h7B && b <= 8'h7E) begin
      r.idx = b - 8'h7B + 8'd157;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Byte of an alphabet position.
  function automatic logic [7:0] sym_byte(input logic [7:0] i);
    logic [7:0] b;
    if (i < 8'd26) begin
      b = 8'h41 + i;
    end else if (i < 8'd52) begin
      b = 8'h61 + (i - 8'd26);
    end else if (i < 8'd58) begin
      b = 8'hC0 + (i - 8'd52);
    end else if (i == 8'd58) begin
      b = 8'hA8;
    end else if (i < 8'd85) begin
      b = 8'hC6 + (i - 8'd59);
    end else if (i < 8'd91) begin
      b = 8'hE0 + (i - 8'd85);
    end else if (i == 8'd91) begin
      b = 8'hB8;
    end else if (i < 8'd118) begin
      b = 8'hE6 + (i - 8'd92);
    end else if (i < 8'd128) begin
      b = 8'h30 + (i - 8'd118);
    end else if (i == 8'd128) begin
      b = 8'h20;
    end else if (i < 8'd144) begin
      b = 8'h21 + (i - 8'd129);
    end else if (i < 8'd151) begin
      b = 8'h3A + (i - 8'd144);
    end else if (i < 8'd157) begin
      b = 8'h5B + (i - 8'd151);
    end else if (i < 8'd161) begin
      b = 8'h7B + (i - 8'd157);
    end else begin
      b = 8'h20;
    end
    return b;
  endfunction

endpackage

// ===== rtl/vigenere_byte_cipher_unit.sv =====
// A byte accepted on the slave side passes through one queue slot, then the
// output register, before it is shown on the master side.
// Throughput: one byte per clock without output stalls; the two-entry queue
// and the output register let the front keep accepting while a result waits.
// Reset (rst, synchronous): key bytes clear, key length returns to 1, mode to
// encrypt, key position to the first byte, queue and output empty.
// ----------------------------------------------------------------------------
// vigenere_byte_cipher_unit
// Byte-stream Vigenere cipher over a 161-symbol Windows-1251 alphabet.
// ----------------------------------------------------------------------------
module vigenere_byte_cipher_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [vbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [vbc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] in_byte
  input  logic                              s_axis_tlast,  // in_last
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [7:0] out_byte
  output logic                              m_axis_tlast   // out_last
);
  import vbc_pkg::*;

  logic [CFG_DATA_W-1:0] key_bytes_low;
  logic [CFG_DATA_W-1:0] key_bytes_high;
  logic [KEY_LEN_W-1:0]  key_length;
  logic                  decrypt_mode;

  logic      push;
  logic      pop;
  logic      queue_full;
  logic      queue_empty;
  vbc_item_t push_item;
  vbc_item_t pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes_low  <= '0;
      key_bytes_high <= '0;
      key_length     <= KEY_LEN_W'(1);
      decrypt_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LOW:  key_bytes_low  <= cfg_data;
        CFG_KEY_HIGH: key_bytes_high <= cfg_data;
        CFG_KEY_LEN:  key_length     <= cfg_data[KEY_LEN_W-1:0];
        CFG_DECRYPT:  decrypt_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  vbc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .key_bytes     ({key_bytes_high, key_bytes_low}),
    .key_length    (key_length),
    .decrypt_mode  (decrypt_mode),
    .queue_full    (queue_full),
    .push          (push),
    .push_item     (push_item)
  );

  vbc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (queue_empty)
  );

  vbc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (queue_empty),
    .pop_item      (pop_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/vbc_front.sv =====
// ----------------------------------------------------------------------------
// vbc_front
// Accepts message bytes, picks the key byte, maps both to alphabet positions
// and tracks the key position.
// ----------------------------------------------------------------------------
module vbc_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] in_byte
  input  logic                              s_axis_tlast,
  input  logic [8*vbc_pkg::KEY_BYTES-1:0]   key_bytes,
  input  logic [vbc_pkg::KEY_LEN_W-1:0]     key_length,
  input  logic                              decrypt_mode,
  input  logic                              queue_full,
  output logic                              push,
  output vbc_pkg::vbc_item_t                push_item
);
  import vbc_pkg::*;

  logic [KEY_POS_W-1:0] key_position;
  logic [KEY_POS_W-1:0] key_position_next;
  logic [KEY_LEN_W-1:0] active_len;
  logic [KEY_LEN_W-1:0] pos_inc;
  logic [7:0]           key_byte;
  sym_idx_t             msg_sym;
  sym_idx_t             key_sym;

  // Hold off transactions while in reset.
  assign s_axis_tready = !rst && !queue_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  // Zero acts as one, anything above the key size acts as the key size.
  always_comb begin
    if (key_length == '0) begin
      active_len = KEY_LEN_W'(1);
    end else if (key_length > KEY_LEN_W'(KEY_BYTES)) begin
      active_len = KEY_LEN_W'(KEY_BYTES);
    end else begin
      active_len = key_length;
    end
  end

  assign key_byte = key_bytes[8*key_position +: 8];
  assign msg_sym  = sym_index(s_axis_tdata);
  assign key_sym  = sym_index(key_byte);

  always_comb begin
    push_item.msg_byte = s_axis_tdata;
    push_item.msg_idx  = msg_sym.idx;
    push_item.msg_ok   = msg_sym.ok;
    push_item.key_idx  = key_sym.idx;
    push_item.key_ok   = key_sym.ok;
    push_item.decrypt  = decrypt_mode;
    push_item.last     = s_axis_tlast;
  end

  assign pos_inc = {1'b0, key_position} + KEY_LEN_W'(1);

  // Wrap at the key length or after the last byte of a message.
  always_comb begin
    key_position_next = key_position;
    if (push) begin
      if (s_axis_tlast || pos_inc >= active_len) begin
        key_position_next = '0;
      end else begin
        key_position_next = pos_inc[KEY_POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position <= '0;
    end else begin
      key_position <= key_position_next;
    end
  end

`ifndef SYNTHESIS
  a_last_restarts_key: assert property (@(posedge clk) disable iff (rst)
    push && s_axis_tlast |=> key_position == '0)
    else $error("key position not restarted after last byte");

  a_position_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !push |=> $stable(key_position))
    else $error("key position moved without a transaction");
`endif

endmodule

// ===== rtl/vbc_queue.sv =====
// ----------------------------------------------------------------------------
// vbc_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module vbc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  vbc_pkg::vbc_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output vbc_pkg::vbc_item_t  pop_item,
  output logic                empty
);
  import vbc_pkg::*;

  vbc_item_t              entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full     = count == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/vbc_back.sv =====
// ----------------------------------------------------------------------------
// vbc_back
// Adds or subtracts alphabet positions modulo the alphabet size, maps the
// result back to a byte and holds it in the output register.
// ----------------------------------------------------------------------------
module vbc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  vbc_pkg::vbc_item_t  pop_item,
  output logic                pop,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // [7:0] out_byte
  output logic                m_axis_tlast
);
  import vbc_pkg::*;

  logic [8:0] sum;
  logic [8:0] res;
  logic [7:0] result_byte;

  assign pop = !empty && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    if (pop_item.decrypt) begin
      if (pop_item.msg_idx >= pop_item.key_idx) begin
        sum = {1'b0, pop_item.msg_idx} - {1'b0, pop_item.key_idx};
      end else begin
        sum = {1'b0, pop_item.msg_idx} + SYMBOLS - {1'b0, pop_item.key_idx};
      end
      res = sum;
    end else begin
      sum = {1'b0, pop_item.msg_idx} + {1'b0, pop_item.key_idx};
      res = (sum >= SYMBOLS) ? sum - SYMBOLS : sum;
    end
  end

  // Pass the byte through when either side falls outside the alphabet.
  assign result_byte = (pop_item.msg_ok && pop_item.key_ok) ? sym_byte(res[7:0])
                                                            : pop_item.msg_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_axis_tdata <= result_byte;
      m_axis_tlast <= pop_item.last;
    end
  end

`ifndef SYNTHESIS
  a_stall_blocks_pop: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !pop)
    else $error("output register overwritten while stalled");
`endif

endmodule

// ===== tb/vigenere_byte_cipher_unit_test.sv =====
// ----------------------------------------------------------------------------
// vigenere_byte_cipher_unit_test
// Drives byte messages through the cipher and checks every output transaction
// against a cycle-free predictor of the cipher. A short table of stimulus opens
// the run (reset state, alphabet edges, wrap, pass-through, key length edge
// cases); random messages under changing keys, modes and flow control follow.
// ----------------------------------------------------------------------------
module vigenere_byte_cipher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vbc_pkg::*;

  localparam int ALPHA_SIZE = 161;
  localparam int LIMIT = 200000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 110;
  localparam logic [63:0] MODE_ENCRYPT = 64'd0;
  localparam logic [63:0] MODE_DECRYPT = 64'd1;
  // Alphabet runs {first, last}, first run in the lowest bits.
  localparam logic [14*16-1:0] RUNS = {
    16'h7B7E, 16'h5B60, 16'h3A40, 16'h212F, 16'h2020, 16'h3039, 16'hE6FF,
    16'hB8B8, 16'hE0E5, 16'hC6DF, 16'hA8A8, 16'hC0C5, 16'h617A, 16'h415A};

  typedef struct {
    logic [7:0] data;
    logic       last;
  } cipher_out_t;

  typedef struct {
    bit         typed;
    logic [7:0] want;
  } pinned_t;

  typedef enum {ROW_BYTE, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [7:0]             data;
    logic                   last;
    bit                     typed;
    logic [7:0]             want;
    logic [CFG_INDEX_W-1:0] idx;
    logic [63:0]            val;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = 8'h00;  // [7:0] in_byte
  logic                   s_axis_tlast = 1'b0;   // in_last
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;          // [7:0] out_byte
  logic                   m_axis_tlast;          // out_last

  // Predictor state
  logic [63:0] key_lo = 64'd0;
  logic [63:0] key_hi = 64'd0;
  logic [4:0]  key_len_reg = 5'd1;
  logic        decipher = 1'b0;
  logic [3:0]  key_pos = 4'd0;

  logic [7:0] glyph [ALPHA_SIZE];
  int         glyph_pos [256];

  cipher_out_t cipher_bytes_q [$];
  pinned_t     pinned_q [$];
  plan_row_t   plan [$];

  int n_in = 0;
  int n_out = 0;
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  vigenere_byte_cipher_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin : build_alphabet
    int n;
    int lo;
    int hi;
    n = 0;
    for (int b = 0; b < 256; b++) glyph_pos[b] = -1;
    for (int r = 0; r < 14; r++) begin
      lo = RUNS[r*16+8 +: 8];
      hi = RUNS[r*16 +: 8];
      for (int b = lo; b <= hi; b++) begin
        glyph[n] = b[7:0];
        glyph_pos[b] = n;
        n++;
      end
    end
  end

  // Cipher one byte with the current key and advance the key position.
  function automatic logic [7:0] vigenere_next(input logic [7:0] msg, input logic lst);
    logic [127:0] key_all;
    logic [7:0]   kb;
    logic [7:0]   res;
    int           len;
    int           mi;
    int           ki;
    key_all = {key_hi, key_lo};
    kb = key_all[int'(key_pos)*8 +: 8];
    len = (key_len_reg == 5'd0) ? 1 : (key_len_reg > KEY_BYTES) ? KEY_BYTES : key_len_reg;
    mi = glyph_pos[msg];
    ki = glyph_pos[kb];
    res = msg;
    if (mi >= 0 && ki >= 0) begin
      if (decipher) res = glyph[(mi + ALPHA_SIZE - ki) % ALPHA_SIZE];
      else res = glyph[(mi + ki) % ALPHA_SIZE];
    end
    if (lst || int'(key_pos) + 1 >= len) key_pos = 4'd0;
    else key_pos = key_pos + 4'd1;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("ERROR at %0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // Check output transactions, predict on input transactions.
  always @(posedge clk) begin : scoreboard
    cipher_out_t exp_out;
    pinned_t     pin;
    logic [7:0]  pred;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_out++;
        if (cipher_bytes_q.size() == 0) begin
          flag_mismatch("unexpected result", m_axis_tdata, 8'h00);
        end else begin
          exp_out = cipher_bytes_q.pop_front();
          if (m_axis_tdata !== exp_out.data) flag_mismatch("out_byte", m_axis_tdata, exp_out.data);
          if (m_axis_tlast !== exp_out.last) begin
            flag_mismatch("out_last", {7'd0, m_axis_tlast}, {7'd0, exp_out.last});
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pin = pinned_q.pop_front();
        pred = vigenere_next(s_axis_tdata, s_axis_tlast);
        if (pin.typed) pred = pin.want;
        cipher_bytes_q.push_back('{data: pred, last: s_axis_tlast});
      end
    end
  end

  // Output side: random stalls, plus a counted hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_KEY_LOW:  key_lo = val;
      CFG_KEY_HIGH: key_hi = val;
      CFG_KEY_LEN:  key_len_reg = val[4:0];
      CFG_DECRYPT:  decipher = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst, input bit typed,
                           input logic [7:0] want);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= lst;
    pinned_q.push_back('{typed: typed, want: want});
    do @(posedge clk); while (!s_axis_tready);
    n_in++;
  endtask

  // Hold the input idle until every result is back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (n_out != n_in) @(posedge clk);
  endtask

  function automatic void row_byte(input logic [7:0] b, input logic lst, input bit typed,
                                   input logic [7:0] want);
    plan.push_back('{kind: ROW_BYTE, data: b, last: lst, typed: typed, want: want,
                     idx: '0, val: 64'd0});
  endfunction

  function automatic void row_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
    plan.push_back('{kind: ROW_REG, data: 8'h00, last: 1'b0, typed: 1'b0, want: 8'h00,
                     idx: idx, val: val});
  endfunction

  function automatic logic [7:0] pick_byte(input int alpha_pct);
    if ($urandom_range(99) < alpha_pct) return glyph[$urandom_range(ALPHA_SIZE - 1)];
    return 8'($urandom_range(255));
  endfunction

  initial begin : stimulus
    int         len_pick [PHASES];
    int         msg_left;
    logic       lst;
    logic [63:0] v;

    len_pick = '{16, 1, 0, 31, 17, 5, 3, 12};

    // Reset key is 0x00, outside the alphabet: every byte passes through.
    row_byte(8'h00, 1'b0, 1'b1, 8'h00);
    row_byte(8'hFF, 1'b0, 1'b1, 8'hFF);
    row_byte(8'h41, 1'b1, 1'b1, 8'h41);
    // Key 'B' shifts by one symbol.
    row_reg(CFG_KEY_LOW, 64'h4242_4242_4242_4242);
    row_byte(8'h41, 1'b0, 1'b1, 8'h42);
    row_byte(8'h5A, 1'b0, 1'b1, 8'h61);
    row_byte(8'h7A, 1'b0, 1'b1, 8'hC0);
    row_byte(8'h7E, 1'b0, 1'b1, 8'h41);  // wraps to the first symbol
    row_byte(8'h7F, 1'b0, 1'b1, 8'h7F);  // not in the alphabet
    row_byte(8'hA8, 1'b0, 1'b1, 8'hC6);
    row_byte(8'hFF, 1'b1, 1'b1, 8'h30);
    row_reg(CFG_DECRYPT, MODE_DECRYPT);
    row_byte(8'h41, 1'b0, 1'b1, 8'h7E);
    row_byte(8'hB8, 1'b0, 1'b1, 8'hE5);
    row_byte(8'h30, 1'b1, 1'b1, 8'hFF);
    // Full-length key with bytes outside the alphabet.
    row_reg(CFG_KEY_LOW, 64'h007E_A8FF_4241_7A5A);
    row_reg(CFG_KEY_HIGH, 64'h8041_B820_21C0_E030);
    row_reg(CFG_KEY_LEN, 64'd16);
    row_reg(CFG_DECRYPT, MODE_ENCRYPT);
    for (int i = 0; i < 5; i++) row_byte(8'h61 + i[7:0], 1'b0, 1'b0, 8'h00);
    // Shorten the key while the position sits past the new end.
    row_reg(CFG_KEY_LEN, 64'd3);
    for (int i = 0; i < 3; i++) row_byte(8'hE0 + i[7:0], 1'b0, 1'b0, 8'h00);
    row_reg(CFG_KEY_LEN, 64'd0);
    row_byte(8'h20, 1'b0, 1'b0, 8'h00);
    row_byte(8'h7E, 1'b1, 1'b0, 8'h00);
    row_reg(CFG_KEY_LEN, 64'd31);
    row_byte(8'h00, 1'b0, 1'b0, 8'h00);
    row_byte(8'hFF, 1'b0, 1'b0, 8'h00);
    row_byte(8'hC5, 1'b1, 1'b0, 8'h00);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (i > 0 && plan[i-1].kind == ROW_BYTE) drain();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_byte(plan[i].data, plan[i].last, plan[i].typed, plan[i].want);
      end
    end

    msg_left = $urandom_range(1, 40);
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      for (int k = 0; k < 8; k++) begin
        v[k*8 +: 8] = pick_byte(85);
      end
      write_reg(CFG_KEY_LOW, v);
      for (int k = 0; k < 8; k++) begin
        v[k*8 +: 8] = pick_byte(85);
      end
      write_reg(CFG_KEY_HIGH, v);
      v = {$urandom, $urandom};
      v[4:0] = 5'(len_pick[ph]);
      write_reg(CFG_KEY_LEN, v);
      v = {$urandom, $urandom};
      v[0] = (ph % 2 == 1) ? MODE_DECRYPT[0] : MODE_ENCRYPT[0];
      write_reg(CFG_DECRYPT, v);

      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      // Back up the output while the input keeps offering bytes.
      if (ph == 4) hold_left = 400;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        msg_left--;
        lst = (msg_left == 0);
        if (lst) msg_left = ($urandom_range(9) == 0) ? 1 : $urandom_range(1, 40);
        send_byte(pick_byte(75), lst, 1'b0, 8'h00);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0 && cipher_bytes_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
